### sv/cnco_pkg.sv
// Shared types and constants of the complex tone generator.
package cnco_pkg;

    // Q2.30 fixed-point constants for the quarter-wave sine table
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          TAYLOR_TERMS = 7;

    // Table magnitude, amplitude and product widths
    localparam int MAG_BITS  = 31;
    localparam int AMP_BITS  = 15;
    localparam int PROD_BITS = MAG_BITS + AMP_BITS;
    localparam int STEP_BITS = 32;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    typedef enum logic [0:0] {
        REG_PHASE_STEP = 1'b0,
        REG_AMPLITUDE  = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

endpackage

### sv/complex_nco_tone_generator_top.sv
// Complex NCO: phase accumulator, quarter-wave sine ROM and I/Q scaling pipeline.
// One I/Q sample per input transaction, one transaction per clock when the output side keeps
// up; an accepted tick passes in order through the ROM read stage, the multiply stage and the
// round/saturate output register. The phase accumulator advances at the accept edge,
// so consecutive ticks never wait on each other; the two-port synchronous sine ROM
// (2^TABLE_ADDR_BITS + 1 entries, filled at elaboration) returns sine and cosine magnitudes in
// the same cycle. A stalled output register holds its sample while earlier stages keep filling.
// Writing phase_step clears the phase; a tick with restart set starts from phase zero.
module complex_nco_tone_generator_top #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // tick channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_restart,
    // sample channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]          o_i_sample,
    output logic signed [SAMPLE_BITS-1:0]          o_q_sample,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [cnco_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [cnco_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [cnco_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);

    localparam int IDX_BITS  = TABLE_ADDR_BITS + 1;
    localparam int ROM_DEPTH = (2 ** TABLE_ADDR_BITS) + 1;
    localparam int SHIFT     = cnco_pkg::PROD_BITS - SAMPLE_BITS;
    localparam int RND_BITS  = cnco_pkg::PROD_BITS + 1;
    localparam int MAG_OUT   = RND_BITS - SHIFT;

    localparam logic [IDX_BITS-1:0] IDX_LAST   = IDX_BITS'(2 ** TABLE_ADDR_BITS);
    localparam logic [RND_BITS-1:0] ROUND_HALF = RND_BITS'(1) << (SHIFT - 1);
    localparam logic [MAG_OUT-1:0]  MAX_POS    = (MAG_OUT'(1) << (SAMPLE_BITS - 1)) - MAG_OUT'(1);
    localparam logic [MAG_OUT-1:0]  MAX_NEG    = MAG_OUT'(1) << (SAMPLE_BITS - 1);

    typedef logic [cnco_pkg::MAG_BITS-1:0] t_rom [ROM_DEPTH];

    // Integer Taylor series of sin(pi/2 * k / 2^A) in Q2.30, clamped to one
    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            x    = (cnco_pkg::HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= cnco_pkg::TAYLOR_TERMS; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = (sum >= term) ? (sum - term) : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            if (sum > cnco_pkg::ONE_Q30) begin
                sum = cnco_pkg::ONE_Q30;
            end
            rom[k] = sum[cnco_pkg::MAG_BITS-1:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = f_build_rom();

    // Round half away from zero on the magnitude, saturate, apply sign
    function automatic logic [SAMPLE_BITS-1:0] f_finish(
        input logic [cnco_pkg::PROD_BITS-1:0] prod,
        input logic                           neg
    );
        logic [RND_BITS-1:0] sum;
        logic [MAG_OUT-1:0]  mag;
        logic [MAG_OUT-1:0]  neg_mag;
        sum = {1'b0, prod} + ROUND_HALF;
        mag = sum[RND_BITS-1:SHIFT];
        if (neg) begin
            neg_mag = (mag > MAX_NEG) ? MAX_NEG : mag;
            return SAMPLE_BITS'(~neg_mag + MAG_OUT'(1));
        end
        return SAMPLE_BITS'((mag > MAX_POS) ? MAX_POS : mag);
    endfunction

    // Configuration registers
    logic [cnco_pkg::STEP_BITS-1:0] r_phase_step;
    logic [cnco_pkg::AMP_BITS-1:0]  r_amplitude;
    logic                           cfg_wr;
    cnco_pkg::t_reg_idx             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = cnco_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_amplitude  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                cnco_pkg::REG_PHASE_STEP: r_phase_step <= pwdata;
                cnco_pkg::REG_AMPLITUDE:  r_amplitude  <= pwdata[cnco_pkg::AMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            cnco_pkg::REG_PHASE_STEP: prdata = r_phase_step;
            cnco_pkg::REG_AMPLITUDE:
                prdata = cnco_pkg::APB_DATA_BITS'(r_amplitude);
            default: prdata = '0;
        endcase
    end

    // Pipeline flow control: a stage loads when it is empty or its successor loads
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic accept;

    assign s3_ready   = !r_out_valid || i_out_ready;
    assign s2_ready   = !r_s2_valid || s3_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_ready = s1_ready;
    assign accept     = i_in_valid && s1_ready;

    // Phase accumulator
    logic [PHASE_BITS-1:0]         r_phase;
    logic [PHASE_BITS-1:0]         n_phase;
    logic [PHASE_BITS-1:0]         cur_phase;
    logic [PHASE_BITS-1:0]         step_units;
    logic [2*cnco_pkg::STEP_BITS-1:0] step_cat;

    // Scale the signed step by 2^(PHASE_BITS-32), arithmetic right when narrower
    assign step_cat   = {r_phase_step, {cnco_pkg::STEP_BITS{1'b0}}};
    assign step_units = step_cat[2*cnco_pkg::STEP_BITS-1 -: PHASE_BITS];
    assign cur_phase  = i_restart ? '0 : r_phase;
    assign n_phase    = cur_phase + step_units;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (cfg_wr && cfg_idx == cnco_pkg::REG_PHASE_STEP) begin
            r_phase <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    // Stage 1: ROM read of sine and cosine magnitudes
    cnco_pkg::t_quad               cur_quad;
    logic [TABLE_ADDR_BITS-1:0]    cur_k;
    logic [IDX_BITS-1:0]           sin_idx;
    logic [IDX_BITS-1:0]           cos_idx;
    cnco_pkg::t_quad               r_s1_quad;
    logic [cnco_pkg::MAG_BITS-1:0] r_s1_sin;
    logic [cnco_pkg::MAG_BITS-1:0] r_s1_cos;

    assign cur_quad = cnco_pkg::t_quad'(cur_phase[PHASE_BITS-1 -: 2]);
    assign cur_k    = cur_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign sin_idx  = {1'b0, cur_k};
    assign cos_idx  = IDX_LAST - {1'b0, cur_k};

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_sin  <= SINE_ROM[sin_idx];
            r_s1_cos  <= SINE_ROM[cos_idx];
            r_s1_quad <= cur_quad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // Stage 2: quadrant mapping and amplitude products
    logic [cnco_pkg::MAG_BITS-1:0]  i_mag;
    logic [cnco_pkg::MAG_BITS-1:0]  q_mag;
    logic                           i_neg;
    logic                           q_neg;
    logic [cnco_pkg::PROD_BITS-1:0] r_s2_iprod;
    logic [cnco_pkg::PROD_BITS-1:0] r_s2_qprod;
    logic                           r_s2_ineg;
    logic                           r_s2_qneg;

    always_comb begin
        case (r_s1_quad)
            cnco_pkg::QUAD_0: begin
                i_mag = r_s1_cos; i_neg = 1'b0;
                q_mag = r_s1_sin; q_neg = 1'b0;
            end
            cnco_pkg::QUAD_1: begin
                i_mag = r_s1_sin; i_neg = 1'b1;
                q_mag = r_s1_cos; q_neg = 1'b0;
            end
            cnco_pkg::QUAD_2: begin
                i_mag = r_s1_cos; i_neg = 1'b1;
                q_mag = r_s1_sin; q_neg = 1'b1;
            end
            default: begin
                i_mag = r_s1_sin; i_neg = 1'b0;
                q_mag = r_s1_cos; q_neg = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready) begin
            r_s2_iprod <= cnco_pkg::PROD_BITS'(r_amplitude) * cnco_pkg::PROD_BITS'(i_mag);
            r_s2_qprod <= cnco_pkg::PROD_BITS'(r_amplitude) * cnco_pkg::PROD_BITS'(q_mag);
            r_s2_ineg  <= i_neg;
            r_s2_qneg  <= q_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage 3: round, saturate and hold for the sample transaction
    logic [SAMPLE_BITS-1:0] r_i_sample;
    logic [SAMPLE_BITS-1:0] r_q_sample;

    always_ff @(posedge i_clk) begin
        if (s3_ready) begin
            r_i_sample <= f_finish(r_s2_iprod, r_s2_ineg);
            r_q_sample <= f_finish(r_s2_qprod, r_s2_qneg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s3_ready) begin
            r_out_valid <= r_s2_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_i_sample  = r_i_sample;
    assign o_q_sample  = r_q_sample;

    // Phase step write restarts the tone from zero phase
    a_step_write_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && cfg_idx == cnco_pkg::REG_PHASE_STEP) |=> (r_phase == '0))
        else $error("phase not cleared after phase step write");

    // Restart tick leaves the phase one step past zero
    a_restart_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_restart && !cfg_wr) |=> (r_phase == $past(step_units)))
        else $error("phase after restart tick is wrong");

    // A blocked product stage keeps its item
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s3_ready) |=> (r_s2_valid && $stable(r_s2_iprod)
            && $stable(r_s2_qprod)))
        else $error("product stage lost its item under stall");

endmodule

### tb/sv/complex_nco_tone_generator_top_tb.sv
// Self-checking testbench for the complex tone generator: directed table, then random register writes and ticks.
module complex_nco_tone_generator_top_tb;

    localparam int CLK_PERIOD   = 20;
    localparam int PHASE_W      = 32;
    localparam int ADDR_W       = 10;
    localparam int SAMPLE_W     = 16;
    localparam int TABLE_TOP    = 1 << ADDR_W;
    localparam int PIPE_LATENCY = 3;
    localparam int RANDOM_TICKS = 1050;
    localparam int MAX_GAP      = 11;
    localparam int AMP_W        = cnco_pkg::AMP_BITS;

    localparam cnco_pkg::t_reg_idx STEP_REG = cnco_pkg::REG_PHASE_STEP;
    localparam cnco_pkg::t_reg_idx AMP_REG  = cnco_pkg::REG_AMPLITUDE;

    typedef struct packed {
        logic [SAMPLE_W-1:0] i_val;
        logic [SAMPLE_W-1:0] q_val;
    } t_iq_pair;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        cnco_pkg::t_reg_idx  reg_sel;
        logic [31:0]         value;
        logic                restart;
        logic                typed;
        logic [SAMPLE_W-1:0] exp_i;
        logic [SAMPLE_W-1:0] exp_q;
    } t_plan_row;

    localparam int PLAN_ROWS = 31;

    // Typed rows land on exact quarter turns; at nonzero gain one output is full scale, the other zero
    t_plan_row plan [0:PLAN_ROWS-1] = '{
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b1, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b1, 1'b1, 16'sd0,      16'sd0},
        '{ROW_CFG,  AMP_REG,  32'h0000_7FFF, 1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b1, 16'sd32767,  16'sd0},
        '{ROW_CFG,  STEP_REG, 32'h4000_0000, 1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b1, 16'sd32767,  16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b1, 16'sd0,      16'sd32767},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b1, -16'sd32767, 16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b1, 16'sd0,      -16'sd32767},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b1, 16'sd32767,  16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b1, 1'b1, 16'sd32767,  16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b1, 16'sd0,      16'sd32767},
        '{ROW_CFG,  STEP_REG, 32'h8000_0000, 1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b1, 16'sd32767,  16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b1, -16'sd32767, 16'sd0},
        '{ROW_CFG,  STEP_REG, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_CFG,  STEP_REG, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_CFG,  AMP_REG,  32'hFFFF_8001, 1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_CFG,  AMP_REG,  32'h0000_4000, 1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_CFG,  STEP_REG, 32'h0123_4567, 1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b1, 1'b0, 16'sd0,      16'sd0},
        '{ROW_TICK, STEP_REG, 32'h0,         1'b0, 1'b0, 16'sd0,      16'sd0}
    };

    logic                               i_clk        = 1'b0;
    logic                               i_rst_n      = 1'b0;
    logic                               tick_valid   = 1'b0;
    logic                               tick_restart = 1'b0;
    logic                               sample_ready = 1'b0;
    logic                               psel         = 1'b0;
    logic                               penable      = 1'b0;
    logic                               pwrite       = 1'b0;
    logic [cnco_pkg::APB_ADDR_BITS-1:0] paddr        = '0;
    logic [cnco_pkg::APB_DATA_BITS-1:0] pwdata       = '0;
    logic [cnco_pkg::APB_DATA_BITS-1:0] prdata;
    logic                               pready;
    logic                               tick_ready;
    logic                               sample_valid;
    logic signed [SAMPLE_W-1:0]         i_sample;
    logic signed [SAMPLE_W-1:0]         q_sample;

    // Predictor state: phase, step and gain as the block should hold them
    logic [PHASE_W-1:0] nco_phase;
    logic [31:0]        nco_step;
    logic [AMP_W-1:0]   nco_amp;
    logic [63:0]        quarter_sine [0:TABLE_TOP];
    t_iq_pair           pending_iq [$];

    bit reset_done    = 1'b0;
    bit sender_steady = 1'b0;
    bit sink_steady   = 1'b0;
    int mismatches    = 0;
    int ticks_sent    = 0;
    int restarts_sent = 0;
    int samples_seen  = 0;
    int reg_writes    = 0;

    complex_nco_tone_generator_top #(
        .PHASE_BITS      (PHASE_W),
        .TABLE_ADDR_BITS (ADDR_W),
        .SAMPLE_BITS     (SAMPLE_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (tick_valid),
        .o_in_ready  (tick_ready),
        .i_restart   (tick_restart),
        .o_out_valid (sample_valid),
        .i_out_ready (sample_ready),
        .o_i_sample  (i_sample),
        .o_q_sample  (q_sample),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Quarter-wave sine in Q2.30 by truncated Taylor series, clamped to one
    initial begin : build_sine
        logic [63:0] x, x2, term, acc;
        for (int k = 0; k <= TABLE_TOP; k++) begin
            x    = (cnco_pkg::HALF_PI_Q30 * 64'(k)) >> ADDR_W;
            x2   = (x * x) >> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= cnco_pkg::TAYLOR_TERMS; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = (acc >= term) ? acc - term : 64'd0;
                end else begin
                    acc = acc + term;
                end
            end
            quarter_sine[k] = (acc > cnco_pkg::ONE_Q30) ? cnco_pkg::ONE_Q30 : acc;
        end
    end

    function automatic logic [SAMPLE_W-1:0] scaled_trig(input logic [AMP_W-1:0] amp,
                                                        input logic [63:0] mag,
                                                        input logic neg);
        logic [63:0] r;
        r = (64'(amp) * mag + (64'd1 << (45 - SAMPLE_W))) >> (46 - SAMPLE_W);
        if (neg) begin
            if (r > (64'd1 << (SAMPLE_W - 1))) r = 64'd1 << (SAMPLE_W - 1);
            return SAMPLE_W'(64'd0 - r);
        end
        if (r > (64'd1 << (SAMPLE_W - 1)) - 1) r = (64'd1 << (SAMPLE_W - 1)) - 1;
        return SAMPLE_W'(r);
    endfunction

    // Form the sample for the current phase (cleared first on restart), then advance the phase by the step
    task automatic advance_tone(input logic restart, output t_iq_pair s);
        logic [ADDR_W+1:0] addr;
        cnco_pkg::t_quad   quad;
        logic [63:0]       sk, ck;
        if (restart) nco_phase = '0;
        addr = nco_phase[PHASE_W-1 -: ADDR_W+2];
        quad = cnco_pkg::t_quad'(addr[ADDR_W+1:ADDR_W]);
        sk   = quarter_sine[int'(addr[ADDR_W-1:0])];
        ck   = quarter_sine[TABLE_TOP - int'(addr[ADDR_W-1:0])];
        case (quad)
            cnco_pkg::QUAD_0: begin
                s = {scaled_trig(nco_amp, ck, 1'b0), scaled_trig(nco_amp, sk, 1'b0)};
            end
            cnco_pkg::QUAD_1: begin
                s = {scaled_trig(nco_amp, sk, 1'b1), scaled_trig(nco_amp, ck, 1'b0)};
            end
            cnco_pkg::QUAD_2: begin
                s = {scaled_trig(nco_amp, ck, 1'b1), scaled_trig(nco_amp, sk, 1'b1)};
            end
            default: begin
                s = {scaled_trig(nco_amp, sk, 1'b0), scaled_trig(nco_amp, ck, 1'b1)};
            end
        endcase
        nco_phase = nco_phase + nco_step;
    endtask

    task automatic send_tick(input logic restart, input logic typed, input t_iq_pair typed_iq);
        int       gap;
        t_iq_pair want;
        gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_valid   <= 1'b1;
        tick_restart <= restart;
        do @(posedge i_clk); while (!tick_ready);
        advance_tone(restart, want);
        pending_iq.push_back(typed ? typed_iq : want);
        ticks_sent++;
        if (restart) restarts_sent++;
    endtask

    // Hold off the sender until every sample in flight has been taken
    task automatic drain_samples();
        tick_valid <= 1'b0;
        while (pending_iq.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 1) @(posedge i_clk);
    endtask

    task automatic cfg_write(input cnco_pkg::t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == cnco_pkg::REG_PHASE_STEP) begin
            nco_step  = val;
            nco_phase = '0;
        end else begin
            nco_amp = val[AMP_W-1:0];
        end
        reg_writes++;
        @(posedge i_clk);
    endtask

    initial begin : sample_sink
        int       hold;
        t_iq_pair want;
        wait (reset_done);
        forever begin
            hold = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0) begin
                sample_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            sample_ready <= 1'b1;
            do @(posedge i_clk); while (!(sample_valid && sample_ready));
            samples_seen++;
            if (pending_iq.size() == 0) begin
                $error("sample transaction with none expected: i=%0d q=%0d", i_sample, q_sample);
                mismatches++;
            end else begin
                want = pending_iq.pop_front();
                if (i_sample !== want.i_val) begin
                    $error("i_sample: expected %0d, got %0d", $signed(want.i_val), i_sample);
                    mismatches++;
                end
                if (q_sample !== want.q_val) begin
                    $error("q_sample: expected %0d, got %0d", $signed(want.q_val), q_sample);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        t_plan_row   row;
        int          random_ticks;
        int          seg_len;
        int          pause_at;
        bit          first_seg;
        logic [31:0] step_val;
        logic [31:0] amp_val;

        nco_phase    = '0;
        nco_step     = '0;
        nco_amp      = '0;
        random_ticks = 0;
        first_seg    = 1'b1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reset_done = 1'b1;

        sender_steady = ($urandom_range(0, 1) == 0);
        sink_steady   = ($urandom_range(0, 1) == 0);
        for (int r = 0; r < PLAN_ROWS; r++) begin
            row = plan[r];
            if (row.kind == ROW_CFG) begin
                drain_samples();
                cfg_write(row.reg_sel, row.value);
            end else begin
                send_tick(row.restart, row.typed, {row.exp_i, row.exp_q});
            end
        end

        while (random_ticks < RANDOM_TICKS) begin
            drain_samples();
            case ($urandom_range(0, 3))
                0: step_val = $urandom();
                1: begin
                    case ($urandom_range(0, 4))
                        0: step_val = 32'h0000_0000;
                        1: step_val = 32'h0000_0001;
                        2: step_val = 32'hFFFF_FFFF;
                        3: step_val = 32'h7FFF_FFFF;
                        default: step_val = 32'h8000_0000;
                    endcase
                end
                2: step_val = $urandom_range(0, 4000) - 2000;
                default: step_val = $urandom() & 32'hF000_0000;
            endcase
            case ($urandom_range(0, 3))
                0: amp_val = $urandom();
                1: amp_val = 32'h0000_7FFF;
                2: amp_val = 32'h0000_0000;
                default: amp_val = $urandom_range(0, 32767);
            endcase
            if (first_seg || $urandom_range(0, 3) != 0) cfg_write(STEP_REG, step_val);
            if (first_seg || $urandom_range(0, 2) != 0) cfg_write(AMP_REG, amp_val);

            sender_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            seg_len  = $urandom_range(15, 70);
            pause_at = (first_seg || $urandom_range(0, 2) == 0) ?
                       $urandom_range(1, seg_len - 1) : -1;
            first_seg = 1'b0;
            for (int n = 0; n < seg_len; n++) begin
                if (n == pause_at) drain_samples();
                send_tick($urandom_range(0, 19) == 0, 1'b0, '0);
                random_ticks++;
            end
        end

        tick_valid <= 1'b0;
        while (pending_iq.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY * 4) @(posedge i_clk);

        $display("Covered %0d ticks (%0d with restart) and %0d register writes;",
                 ticks_sent, restarts_sent, reg_writes);
        $display("%0d samples compared, %0d mismatches.", samples_seen, mismatches);
        if (mismatches == 0) begin
            $display("** complex_nco_tone_generator_top: PASSED **");
        end else begin
            $display("** complex_nco_tone_generator_top: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * 400_000);
        $display("Timed out with %0d samples outstanding.", pending_iq.size());
        $display("** complex_nco_tone_generator_top: FAILED **");
        $finish;
    end

endmodule
